/* hw/rtl/gssc_pkg.sv */
// Shared types and constants for the two-servo gear shift controller.
// Used by every module of the block; depends on nothing else.
package gssc_pkg;

  localparam int GEAR_W  = 4;
  localparam int PULSE_W = 12;

  // Upper clamp for a tuned servo position, in microseconds.
  localparam logic [PULSE_W-1:0] TUNE_MAX = 12'd3500;

  // Division by seven of a value below 4096: (m * 4682) >> 15 is exact there.
  localparam logic [12:0] OVS_RECIP = 13'd4682;
  localparam int          OVS_SHIFT = 15;

  typedef enum logic [2:0] {
    FN_TICK      = 3'd0,
    FN_UP        = 3'd1,
    FN_DOWN      = 3'd2,
    FN_TO        = 3'd3,
    FN_TUNE_UP   = 3'd4,
    FN_TUNE_DOWN = 3'd5,
    FN_LOAD      = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    CFG_FRONT_COUNT = 3'd0,
    CFG_REAR_COUNT  = 3'd1,
    CFG_FRONT_STEP  = 3'd2,
    CFG_REAR_STEP   = 3'd3,
    CFG_DELAY       = 3'd4,
    CFG_CHAN_EN     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  front_count;
    logic [4:0]  rear_count;
    logic [7:0]  front_step;
    logic [7:0]  rear_step;
    logic [15:0] delay;
    logic [1:0]  chan_en;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    front_count: 3'd2,
    rear_count:  5'd11,
    front_step:  8'd10,
    rear_step:   8'd10,
    delay:       16'd500,
    chan_en:     2'd0
  };

  // Table write request from the step logic.
  typedef struct packed {
    logic               en;
    logic               ch;
    logic [GEAR_W-1:0]  idx;
    logic [PULSE_W-1:0] data;
  } tbl_wr_t;

  // Gear numbers the step logic wants looked up.
  typedef struct packed {
    logic [GEAR_W-1:0] front_g;
    logic [GEAR_W-1:0] rear_g;
    logic [GEAR_W-1:0] rear_nb;
  } tbl_addr_t;

  typedef struct packed {
    logic [PULSE_W-1:0] front_t;
    logic [PULSE_W-1:0] rear_t;
    logic [PULSE_W-1:0] rear_nb;
  } tbl_rd_t;

  typedef struct packed {
    logic               pulse_write;
    logic               pulse_channel;
    logic [PULSE_W-1:0] pulse_us;
    logic [GEAR_W-1:0]  gear_now;
    logic [PULSE_W-1:0] position_now;
    logic               status;
  } res_t;

endpackage

/* hw/rtl/two_servo_gear_shift_controller.sv */
// An accepted item waits in the input register until it commits, which it can do only
// while the output register is empty or being drained; its result is then written to
// the output register. Throughput: one item per cycle while out_tready stays high,
// set by the single pass through table read, overshoot multiply and saturation.
// Reset (rst_n low, synchronous): channel state, timer, handshakes and config
// registers return to their reset values; the pulse tables are not cleared.
module two_servo_gear_shift_controller #(
  parameter int FRONT_GEARS = 6,
  parameter int REAR_GEARS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // gear_index[3:0], pulse_value[15:4]
  input  logic [3:0]  in_tuser,   // func[2:0], channel[3]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pulse_us[11:0], gear_now[15:12], position_now[27:16]
  output logic [2:0]  out_tuser,  // pulse_write[0], pulse_channel[1], status[2]
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Input register: the item that is being worked on this cycle.
  logic        in_v_r;
  logic [2:0]  in_func_r;
  logic        in_ch_r;
  logic [3:0]  in_gi_r;
  logic [11:0] in_pv_r;

  // Channel state of both servos and the rear correction timer.
  logic [1:0][3:0]  gear_r,  gear_nxt;
  logic [1:0][11:0] pos_r,   pos_nxt;
  logic             pend_r,  pend_nxt;
  logic [15:0]      ticks_r, ticks_nxt;

  // Output register.
  logic           out_v_r;
  gssc_pkg::res_t out_res_r;

  gssc_pkg::cfg_t      cfg;
  gssc_pkg::tbl_wr_t   twr;
  gssc_pkg::tbl_wr_t   twr_gated;
  gssc_pkg::tbl_addr_t taddr;
  gssc_pkg::tbl_rd_t   trd;
  gssc_pkg::res_t      res;

  logic adv;
  logic commit;

  // The output register can take a new result when it is empty or being drained;
  // the item in the input register commits its state changes on that edge.
  assign adv       = !out_v_r || out_tready;
  assign commit    = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  gssc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A table load only takes effect when its item commits.
  always_comb begin
    twr_gated    = twr;
    twr_gated.en = twr.en && commit;
  end

  gssc_table #(
    .FRONT_GEARS (FRONT_GEARS),
    .REAR_GEARS  (REAR_GEARS)
  ) u_table (
    .clk  (clk),
    .wr   (twr_gated),
    .addr (taddr),
    .rd   (trd)
  );

  gssc_step #(
    .FRONT_GEARS (FRONT_GEARS),
    .REAR_GEARS  (REAR_GEARS)
  ) u_step (
    .func      (in_func_r),
    .ch        (in_ch_r),
    .gi        (in_gi_r),
    .pv        (in_pv_r),
    .cfg       (cfg),
    .gear_r    (gear_r),
    .pos_r     (pos_r),
    .pend_r    (pend_r),
    .ticks_r   (ticks_r),
    .rd        (trd),
    .taddr     (taddr),
    .twr       (twr),
    .gear_nxt  (gear_nxt),
    .pos_nxt   (pos_nxt),
    .pend_nxt  (pend_nxt),
    .ticks_nxt (ticks_nxt),
    .res       (res)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= in_tuser[2:0];
      in_ch_r   <= in_tuser[3];
      in_gi_r   <= in_tdata[3:0];
      in_pv_r   <= in_tdata[15:4];
    end
  end

  // Channel state only moves when an item commits, so back-to-back items each
  // see the state left by the one before.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r  <= '0;
      pos_r   <= '0;
      pend_r  <= 1'b0;
      ticks_r <= '0;
    end else if (commit) begin
      gear_r  <= gear_nxt;
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_res_r.position_now, out_res_r.gear_now,
                       out_res_r.pulse_us};
  assign out_tuser  = {out_res_r.status, out_res_r.pulse_channel, out_res_r.pulse_write};

  // An item that commits reaches the output register on the next edge.
  a_commit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_v_r)
    else $error("committed item did not reach the output register");

  // A result without a pulse carries zero in its pulse fields.
  a_idle_pulse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_res_r.pulse_write) |->
      (!out_res_r.pulse_channel && (out_res_r.pulse_us == 12'd0)))
    else $error("pulse fields set without a pulse command");

  // An ignored request never commands a pulse.
  a_ignored_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.status) |-> !out_res_r.pulse_write)
    else $error("ignored item commanded a pulse");

  // Stored gears always address an entry of their own table.
  a_gear_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, gear_r[0]} < 5'(FRONT_GEARS)) && ({1'b0, gear_r[1]} < 5'(REAR_GEARS)))
    else $error("stored gear beyond table depth");

endmodule

/* hw/rtl/gssc_cfg.sv */
// Configuration register file of the gear shift controller.
// Depends on gssc_pkg for the register layout, indexes and reset values.
module gssc_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output gssc_pkg::cfg_t    cfg
);

  gssc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= gssc_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gssc_pkg::CFG_FRONT_COUNT: cfg_r.front_count <= cfg_data[2:0];
        gssc_pkg::CFG_REAR_COUNT:  cfg_r.rear_count  <= cfg_data[4:0];
        gssc_pkg::CFG_FRONT_STEP:  cfg_r.front_step  <= cfg_data[7:0];
        gssc_pkg::CFG_REAR_STEP:   cfg_r.rear_step   <= cfg_data[7:0];
        gssc_pkg::CFG_DELAY:       cfg_r.delay       <= cfg_data;
        gssc_pkg::CFG_CHAN_EN:     cfg_r.chan_en     <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/gssc_table.sv */
// Gear-to-pulse tables: one front table and two identical copies of the rear
// table, so the shift target and its neighbour are each read at one address.
// Depends on gssc_pkg for the request and read-data structs.
module gssc_table #(
  parameter int FRONT_GEARS = 6,
  parameter int REAR_GEARS  = 16
) (
  input  logic                clk,
  input  gssc_pkg::tbl_wr_t   wr,
  input  gssc_pkg::tbl_addr_t addr,
  output gssc_pkg::tbl_rd_t   rd
);

  localparam int FA_W = (FRONT_GEARS > 1) ? $clog2(FRONT_GEARS) : 1;
  localparam int RA_W = $clog2(REAR_GEARS);

  logic [gssc_pkg::PULSE_W-1:0] front_mem [FRONT_GEARS];
  logic [gssc_pkg::PULSE_W-1:0] rear_a    [REAR_GEARS];
  logic [gssc_pkg::PULSE_W-1:0] rear_b    [REAR_GEARS];

  // Entries have no reset; an entry is meaningful once it has been loaded.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.ch) begin
        rear_a[wr.idx[RA_W-1:0]] <= wr.data;
        rear_b[wr.idx[RA_W-1:0]] <= wr.data;
      end else begin
        front_mem[wr.idx[FA_W-1:0]] <= wr.data;
      end
    end
  end

  assign rd.front_t = front_mem[addr.front_g[FA_W-1:0]];
  assign rd.rear_t  = rear_a[addr.rear_g[RA_W-1:0]];
  assign rd.rear_nb = rear_b[addr.rear_nb[RA_W-1:0]];

endmodule

/* hw/rtl/gssc_step.sv */
// Single-pass step logic: decodes one item, computes the next channel state,
// the table request and the result. Depends on gssc_pkg.
module gssc_step #(
  parameter int FRONT_GEARS = 6,
  parameter int REAR_GEARS  = 16
) (
  input  logic [2:0]                        func,
  input  logic                              ch,
  input  logic [3:0]                        gi,
  input  logic [11:0]                       pv,
  input  gssc_pkg::cfg_t                    cfg,
  input  logic [1:0][3:0]                   gear_r,
  input  logic [1:0][11:0]                  pos_r,
  input  logic                              pend_r,
  input  logic [15:0]                       ticks_r,
  input  gssc_pkg::tbl_rd_t                 rd,
  output gssc_pkg::tbl_addr_t               taddr,
  output gssc_pkg::tbl_wr_t                 twr,
  output logic [1:0][3:0]                   gear_nxt,
  output logic [1:0][11:0]                  pos_nxt,
  output logic                              pend_nxt,
  output logic [15:0]                       ticks_nxt,
  output gssc_pkg::res_t                    res
);

  localparam logic [4:0] FRONT_D = 5'(FRONT_GEARS);
  localparam logic [4:0] REAR_D  = 5'(REAR_GEARS);

  logic        enabled;
  logic [4:0]  cnt_raw;
  logic [4:0]  depth;
  logic [4:0]  usable;
  logic [3:0]  cur;
  logic [3:0]  target;
  logic        shift_ok;

  logic [11:0] t_val;
  logic [12:0] diff;
  logic        diff_neg;
  logic [11:0] mag;
  logic [24:0] prod;
  logic [9:0]  quo;
  logic [13:0] ovs_sum;
  logic [11:0] ovs_us;

  logic [7:0]  step;
  logic [12:0] up_sum;
  logic [11:0] up_val;
  logic [11:0] dn_val;
  logic [11:0] tune_val;

  assign enabled = cfg.chan_en[ch];
  assign cnt_raw = ch ? cfg.rear_count : {2'b00, cfg.front_count};
  assign depth   = ch ? REAR_D : FRONT_D;
  assign usable  = (cnt_raw == 5'd0) ? 5'd1 : ((cnt_raw > depth) ? depth : cnt_raw);
  assign cur     = gear_r[ch];

  always_comb begin
    target   = cur;
    shift_ok = 1'b0;
    unique case (func)
      gssc_pkg::FN_UP: begin
        target   = cur + 4'd1;
        shift_ok = enabled && (({1'b0, cur} + 5'd1) < usable);
      end
      gssc_pkg::FN_DOWN: begin
        target   = cur - 4'd1;
        shift_ok = enabled && (cur != 4'd0);
      end
      gssc_pkg::FN_TO: begin
        target   = gi;
        shift_ok = enabled && ({1'b0, gi} < usable);
      end
      default: begin
      end
    endcase
  end

  // The tick correction reads the rear entry of the current rear gear.
  assign taddr.front_g = target;
  assign taddr.rear_g  = (func == gssc_pkg::FN_TICK) ? gear_r[1] : target;
  assign taddr.rear_nb = (target > gear_r[1]) ? (target - 4'd1) : (target + 4'd1);

  // Overshoot: t + (t - n) / 7, truncated toward zero, saturated to 12 bits.
  assign t_val    = ch ? rd.rear_t : rd.front_t;
  assign diff     = {1'b0, t_val} - {1'b0, rd.rear_nb};
  assign diff_neg = diff[12];
  assign mag      = diff_neg ? 12'((~diff) + 13'd1) : diff[11:0];
  assign prod     = 25'(mag) * 25'(gssc_pkg::OVS_RECIP);
  assign quo      = prod[gssc_pkg::OVS_SHIFT+9:gssc_pkg::OVS_SHIFT];
  assign ovs_sum  = diff_neg ? ({2'b00, t_val} - {4'b0000, quo})
                             : ({2'b00, t_val} + {4'b0000, quo});
  assign ovs_us   = ovs_sum[13] ? 12'd0 : (ovs_sum[12] ? 12'hFFF : ovs_sum[11:0]);

  // Tune arithmetic.
  assign step     = ch ? cfg.rear_step : cfg.front_step;
  assign up_sum   = {1'b0, pos_r[ch]} + {5'b00000, step};
  assign up_val   = (up_sum > {1'b0, gssc_pkg::TUNE_MAX}) ? gssc_pkg::TUNE_MAX : up_sum[11:0];
  assign dn_val   = (pos_r[ch] < {4'b0000, step}) ? 12'd0 : (pos_r[ch] - {4'b0000, step});
  assign tune_val = (func == gssc_pkg::FN_TUNE_UP) ? up_val : dn_val;

  always_comb begin
    gear_nxt  = gear_r;
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    ticks_nxt = ticks_r;
    twr.en    = 1'b0;
    twr.ch    = ch;
    twr.idx   = gi;
    twr.data  = pv;
    res       = '0;

    unique case (func)
      gssc_pkg::FN_TICK: begin
        if (pend_r) begin
          if (ticks_r >= cfg.delay) begin
            if (cfg.chan_en[1]) begin
              res.pulse_write   = 1'b1;
              res.pulse_channel = 1'b1;
              res.pulse_us      = rd.rear_t;
            end
            pend_nxt = 1'b0;
          end else begin
            ticks_nxt = ticks_r + 16'd1;
          end
        end
      end
      gssc_pkg::FN_UP, gssc_pkg::FN_DOWN, gssc_pkg::FN_TO: begin
        res.status = !shift_ok;
      end
      gssc_pkg::FN_TUNE_UP, gssc_pkg::FN_TUNE_DOWN: begin
        if (enabled) begin
          pos_nxt[ch]       = tune_val;
          res.pulse_write   = 1'b1;
          res.pulse_channel = ch;
          res.pulse_us      = tune_val;
        end else begin
          res.status = 1'b1;
        end
      end
      gssc_pkg::FN_LOAD: begin
        if ({1'b0, gi} < depth) begin
          twr.en = 1'b1;
        end else begin
          res.status = 1'b1;
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase

    if (shift_ok) begin
      ticks_nxt = 16'd0;
      pend_nxt  = 1'b1;
      if (!ch) begin
        res.pulse_write   = 1'b1;
        res.pulse_channel = 1'b0;
        res.pulse_us      = t_val;
      end else if (target != gear_r[1]) begin
        res.pulse_write   = 1'b1;
        res.pulse_channel = 1'b1;
        res.pulse_us      = ovs_us;
      end
      pos_nxt[ch]  = t_val;
      gear_nxt[ch] = target;
    end

    res.gear_now     = gear_nxt[ch];
    res.position_now = pos_nxt[ch];
  end

endmodule

/* tb/gear_shift_checker.sv */
// Result checker for the two-servo gear shift controller testbench.
// Tracks register writes and accepted items, predicts every result and compares it.
// Depends on gssc_pkg for the field widths, codes and the result layout.
`timescale 1ns / 100ps

module gear_shift_checker #(
  parameter int FRONT_GEARS = 6,
  parameter int REAR_GEARS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outstanding,
  output int          pulse_cmds,
  output int          ignored_reqs
);

  localparam int SLOTS         = FRONT_GEARS + REAR_GEARS;
  localparam int OVERSHOOT_DIV = 7;
  localparam int PULSE_MAX     = (1 << gssc_pkg::PULSE_W) - 1;

  gssc_pkg::cfg_t               setup;
  logic [gssc_pkg::PULSE_W-1:0] pulse_tbl [SLOTS];
  logic [gssc_pkg::GEAR_W-1:0]  gear_at [2];
  logic [gssc_pkg::PULSE_W-1:0] pos_at [2];
  logic                         armed;
  logic [15:0]                  tick_cnt;
  gssc_pkg::res_t               expected_cmds [$];
  int                           errs;
  int                           pulses;
  int                           ignored;

  function automatic int usable(logic ch);
    int cnt;
    int lim;
    cnt = ch ? int'(setup.rear_count) : int'(setup.front_count);
    lim = ch ? REAR_GEARS : FRONT_GEARS;
    if (cnt < 1) cnt = 1;
    if (cnt > lim) cnt = lim;
    return cnt;
  endfunction

  function automatic int slot(logic ch, logic [gssc_pkg::GEAR_W-1:0] g);
    return (ch ? FRONT_GEARS : 0) + int'(g);
  endfunction

  function automatic gssc_pkg::res_t servo_step(logic [2:0] fn, logic ch,
                                                logic [gssc_pkg::GEAR_W-1:0] gi,
                                                logic [gssc_pkg::PULSE_W-1:0] pv);
    gssc_pkg::res_t              r;
    logic                        live;
    logic                        move;
    logic [gssc_pkg::GEAR_W-1:0] tgt;
    logic [gssc_pkg::GEAR_W-1:0] nb;
    int                          t;
    int                          n;
    int                          p;
    int                          step;
    r    = '0;
    live = setup.chan_en[ch];
    move = 1'b0;
    tgt  = '0;
    case (fn)
      gssc_pkg::FN_TICK: begin
        if (armed) begin
          if (tick_cnt >= setup.delay) begin
            if (setup.chan_en[1]) begin
              r.pulse_write   = 1'b1;
              r.pulse_channel = 1'b1;
              r.pulse_us      = pulse_tbl[slot(1'b1, gear_at[1])];
            end
            armed = 1'b0;
          end else begin
            tick_cnt = tick_cnt + 16'd1;
          end
        end
      end
      gssc_pkg::FN_UP: begin
        if (live && int'(gear_at[ch]) + 1 < usable(ch)) begin
          tgt  = gear_at[ch] + 1'b1;
          move = 1'b1;
        end else r.status = 1'b1;
      end
      gssc_pkg::FN_DOWN: begin
        if (live && gear_at[ch] != '0) begin
          tgt  = gear_at[ch] - 1'b1;
          move = 1'b1;
        end else r.status = 1'b1;
      end
      gssc_pkg::FN_TO: begin
        if (live && int'(gi) < usable(ch)) begin
          tgt  = gi;
          move = 1'b1;
        end else r.status = 1'b1;
      end
      gssc_pkg::FN_TUNE_UP, gssc_pkg::FN_TUNE_DOWN: begin
        if (live) begin
          step = ch ? int'(setup.rear_step) : int'(setup.front_step);
          p    = int'(pos_at[ch]);
          if (fn == gssc_pkg::FN_TUNE_UP) begin
            p = p + step;
            if (p > int'(gssc_pkg::TUNE_MAX)) p = int'(gssc_pkg::TUNE_MAX);
          end else begin
            p = p - step;
            if (p < 0) p = 0;
          end
          pos_at[ch]      = p[gssc_pkg::PULSE_W-1:0];
          r.pulse_write   = 1'b1;
          r.pulse_channel = ch;
          r.pulse_us      = pos_at[ch];
        end else r.status = 1'b1;
      end
      gssc_pkg::FN_LOAD: begin
        if (int'(gi) < (ch ? REAR_GEARS : FRONT_GEARS)) pulse_tbl[slot(ch, gi)] = pv;
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase

    if (move) begin
      t        = int'(pulse_tbl[slot(ch, tgt)]);
      tick_cnt = '0;
      armed    = 1'b1;
      if (!ch) begin
        r.pulse_write   = 1'b1;
        r.pulse_channel = 1'b0;
        r.pulse_us      = t[gssc_pkg::PULSE_W-1:0];
      end else if (tgt != gear_at[1]) begin
        // The rear servo overshoots past the target, away from the gear it leaves.
        nb = (tgt > gear_at[1]) ? tgt - 1'b1 : tgt + 1'b1;
        n  = int'(pulse_tbl[slot(1'b1, nb)]);
        p  = t + (t - n) / OVERSHOOT_DIV;
        if (p < 0) p = 0;
        else if (p > PULSE_MAX) p = PULSE_MAX;
        r.pulse_write   = 1'b1;
        r.pulse_channel = 1'b1;
        r.pulse_us      = p[gssc_pkg::PULSE_W-1:0];
      end
      pos_at[ch]  = t[gssc_pkg::PULSE_W-1:0];
      gear_at[ch] = tgt;
    end

    r.gear_now     = gear_at[ch];
    r.position_now = pos_at[ch];
    return r;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : watch
    gssc_pkg::res_t want;
    if (!rst_n) begin
      setup      = gssc_pkg::CFG_RESET;
      gear_at[0] = '0;
      gear_at[1] = '0;
      pos_at[0]  = '0;
      pos_at[1]  = '0;
      armed      = 1'b0;
      tick_cnt   = '0;
      expected_cmds.delete();
      errs    = 0;
      pulses  = 0;
      ignored = 0;
    end else begin
      // A result can never belong to an item taken at the same edge, so
      // results are retired before the new item is predicted.
      if (out_tvalid && out_tready) begin
        if (out_tuser[0]) pulses++;
        if (out_tuser[2]) ignored++;
        if (expected_cmds.size() == 0) begin
          $error("result with no item outstanding: tdata %h tuser %h", out_tdata, out_tuser);
          errs++;
        end else begin
          want = expected_cmds.pop_front();
          compare_field("pulse_write", int'(want.pulse_write), int'(out_tuser[0]));
          compare_field("pulse_channel", int'(want.pulse_channel), int'(out_tuser[1]));
          compare_field("pulse_us", int'(want.pulse_us), int'(out_tdata[11:0]));
          compare_field("gear_now", int'(want.gear_now), int'(out_tdata[15:12]));
          compare_field("position_now", int'(want.position_now), int'(out_tdata[27:16]));
          compare_field("status", int'(want.status), int'(out_tuser[2]));
        end
      end
      if (in_tvalid && in_tready)
        expected_cmds.push_back(servo_step(in_tuser[2:0], in_tuser[3], in_tdata[3:0],
                                           in_tdata[15:4]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gssc_pkg::CFG_FRONT_COUNT: setup.front_count = cfg_data[2:0];
          gssc_pkg::CFG_REAR_COUNT:  setup.rear_count  = cfg_data[4:0];
          gssc_pkg::CFG_FRONT_STEP:  setup.front_step  = cfg_data[7:0];
          gssc_pkg::CFG_REAR_STEP:   setup.rear_step   = cfg_data[7:0];
          gssc_pkg::CFG_DELAY:       setup.delay       = cfg_data;
          gssc_pkg::CFG_CHAN_EN:     setup.chan_en     = cfg_data[1:0];
          default: ;
        endcase
      end
    end
    fail_count   <= errs;
    outstanding  <= expected_cmds.size();
    pulse_cmds   <= pulses;
    ignored_reqs <= ignored;
  end

endmodule

/* tb/two_servo_gear_shift_controller_test.sv */
// Top of the two-servo gear shift controller testbench: clock, reset, stimulus and verdict.
// Depends on gssc_pkg, the controller RTL and gear_shift_checker.
`timescale 1ns / 100ps

module two_servo_gear_shift_controller_test;

  localparam int FRONT_GEARS    = 6;
  localparam int REAR_GEARS     = 16;
  localparam int TARGET_CMDS    = 1600;
  localparam int PHASE_CMDS     = 120;
  localparam int MAX_GAP        = 18;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int QUIET_LIMIT    = 2000;

  // Codes the package leaves unnamed: the unused function and the unused
  // register indexes. All of them must be ignored by the block.
  localparam logic [2:0] FN_SPARE     = 3'd7;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam logic       FRONT        = 1'b0;
  localparam logic       REAR         = 1'b1;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_ready;

  int             fail_count;
  int             outstanding;
  int             pulse_cmds;
  int             ignored_reqs;
  int             cmds_sent    = 0;
  int             reg_writes   = 0;
  int             phases       = 0;
  int             quiet_cycles = 0;
  bit             tx_burst     = 1'b0;
  bit             rx_burst     = 1'b0;
  bit             squeeze_req  = 1'b0;
  gssc_pkg::cfg_t cur;

  always #2 clk = ~clk;

  two_servo_gear_shift_controller #(
    .FRONT_GEARS(FRONT_GEARS),
    .REAR_GEARS (REAR_GEARS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gear_shift_checker #(
    .FRONT_GEARS(FRONT_GEARS),
    .REAR_GEARS (REAR_GEARS)
  ) cmd_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .pulse_cmds  (pulse_cmds),
    .ignored_reqs(ignored_reqs)
  );

  // Offers one item after a random gap and returns at the edge where it is
  // taken. The valid is only lowered when a gap follows, so back-to-back
  // items keep it high without a glitch.
  task automatic send_cmd(input logic [2:0] fn, input logic ch, input logic [3:0] gi,
                          input logic [11:0] pv);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {ch, fn};
    in_tdata  <= {pv, gi};
    do @(posedge clk); while (!in_tready);
    cmds_sent++;
  endtask

  // Drives one register write and holds it until it is taken. The caller
  // lowers the valid once its whole burst of writes is done.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  // Writes every register. With noise on, the bits above each field carry
  // random junk that the block must drop, and the unused indexes get a write.
  task automatic apply_settings(input gssc_pkg::cfg_t s, input bit noisy);
    logic [15:0] junk [6];
    foreach (junk[i]) junk[i] = noisy ? 16'($urandom) : 16'd0;
    write_reg(gssc_pkg::CFG_FRONT_COUNT, {junk[0][15:3], s.front_count});
    write_reg(gssc_pkg::CFG_REAR_COUNT, {junk[1][15:5], s.rear_count});
    write_reg(gssc_pkg::CFG_FRONT_STEP, {junk[2][15:8], s.front_step});
    write_reg(gssc_pkg::CFG_REAR_STEP, {junk[3][15:8], s.rear_step});
    write_reg(gssc_pkg::CFG_DELAY, s.delay);
    write_reg(gssc_pkg::CFG_CHAN_EN, {junk[4][15:2], s.chan_en});
    if (noisy) begin
      write_reg(CFG_SPARE_LO, junk[5]);
      write_reg(CFG_SPARE_HI, ~junk[5]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur = s;
  endtask

  // Waits until every item has its result back. The checker's count is
  // registered, hence the first step before looking at it.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, stretches with none, and one long hold-off
  // once the stimulus asks for it, so that the block backs up into its input.
  initial begin : sink
    int stall;
    int taken;
    bit squeezed;
    taken    = 0;
    squeezed = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (squeeze_req && !squeezed) begin
        stall    = SQUEEZE_CYCLES;
        squeezed = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Ends the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $error("no handshake for %0d cycles", QUIET_LIMIT);
      $display("two_servo_gear_shift_controller_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    gssc_pkg::cfg_t s;
    int             ticks;
    int             r;
    logic [2:0]     fn;
    logic [3:0]     gi;
    logic [11:0]    pv;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur = gssc_pkg::CFG_RESET;

    // Fill the whole pulse table first, so no later lookup can hit an entry
    // that was never written. The first rear gears swing between the extremes
    // so that the overshoot saturates at both ends.
    for (int g = 0; g < FRONT_GEARS; g++)
      send_cmd(gssc_pkg::FN_LOAD, FRONT, 4'(g),
               (g == 0) ? 12'd100 : (g == FRONT_GEARS - 1) ? 12'd3400
                                  : 12'($urandom_range(500, 2500)));
    for (int g = 0; g < REAR_GEARS; g++)
      send_cmd(gssc_pkg::FN_LOAD, REAR, 4'(g),
               (g == 1) ? 12'd0 : (g < 3) ? 12'hFFF : 12'($urandom_range(0, 4095)));

    // Both servos are detached after reset: everything but a tick or an in-range table load is ignored.
    send_cmd(gssc_pkg::FN_UP, FRONT, 0, 0);
    send_cmd(gssc_pkg::FN_TUNE_UP, REAR, 0, 0);
    send_cmd(FN_SPARE, FRONT, 0, 0);
    send_cmd(gssc_pkg::FN_LOAD, FRONT, 15, '1);
    send_cmd(gssc_pkg::FN_LOAD, FRONT, 4'(FRONT_GEARS), 12'd1234);
    send_cmd(gssc_pkg::FN_TICK, REAR, 0, 0);
    drain;

    // Full gear ranges, largest tune steps, immediate correction.
    s = '{front_count: 3'd6, rear_count: 5'd16, front_step: 8'd255, rear_step: 8'd255,
          delay: 16'd0, chan_en: 2'b11};
    apply_settings(s, 1'b0);
    send_cmd(gssc_pkg::FN_UP, REAR, 0, 0);        // overshoot below zero, saturates low
    send_cmd(gssc_pkg::FN_UP, REAR, 0, 0);        // overshoot above the top, saturates high
    send_cmd(gssc_pkg::FN_DOWN, REAR, 0, 0);
    send_cmd(gssc_pkg::FN_TO, REAR, 1, 0);        // same gear: timer armed, no pulse
    send_cmd(gssc_pkg::FN_TICK, FRONT, 0, 0);     // zero delay fires on the first tick
    send_cmd(gssc_pkg::FN_TICK, REAR, 0, 0);      // nothing pending any more
    send_cmd(gssc_pkg::FN_TO, REAR, 15, 0);
    send_cmd(gssc_pkg::FN_UP, REAR, 0, 0);        // already at the top gear
    send_cmd(gssc_pkg::FN_TO, FRONT, 5, 0);
    send_cmd(gssc_pkg::FN_TUNE_UP, FRONT, 0, 0);  // clamps at the tune ceiling
    send_cmd(gssc_pkg::FN_TUNE_UP, FRONT, 0, 0);
    send_cmd(gssc_pkg::FN_TO, FRONT, 0, 0);
    send_cmd(gssc_pkg::FN_TUNE_DOWN, FRONT, 0, 0);  // clamps at zero
    send_cmd(gssc_pkg::FN_DOWN, FRONT, 0, 0);     // already at gear zero
    send_cmd(gssc_pkg::FN_TO, FRONT, 4'(FRONT_GEARS), 0);  // beyond the usable front gears
    send_cmd(gssc_pkg::FN_TO, FRONT, 15, 0);
    send_cmd(gssc_pkg::FN_TUNE_DOWN, REAR, 0, 0);
    send_cmd(gssc_pkg::FN_LOAD, REAR, 15, '1);
    send_cmd(gssc_pkg::FN_LOAD, FRONT, 5, '0);
    send_cmd(FN_SPARE, REAR, 15, '1);
    drain;

    // Random phases: a few fixed corner settings, then random ones.
    while (cmds_sent < TARGET_CMDS) begin
      case (phases)
        0: s = '{front_count: 3'd7, rear_count: 5'd31, front_step: 8'd1,
                 rear_step: 8'd128, delay: 16'd5, chan_en: 2'b11};
        1: s = '{front_count: 3'd1, rear_count: 5'd1, front_step: 8'd0,
                 rear_step: 8'd0, delay: 16'd1, chan_en: 2'b11};
        2: s = '{front_count: 3'd0, rear_count: 5'd0, front_step: 8'd200,
                 rear_step: 8'd3, delay: 16'hFFFF, chan_en: 2'b10};
        3: s = '{front_count: 3'd3, rear_count: 5'd2, front_step: 8'd17,
                 rear_step: 8'd90, delay: 16'd2, chan_en: 2'b01};
        default: begin
          s.front_count = 3'($urandom_range(0, 7));
          s.rear_count  = 5'($urandom_range(0, 31));
          s.front_step  = 8'($urandom);
          s.rear_step   = 8'($urandom);
          s.delay       = 16'($urandom_range(0, 10));
          s.chan_en     = 2'($urandom);
          if ($urandom_range(0, 1) == 1) s.chan_en = 2'b11;
        end
      endcase
      apply_settings(s, phases != 1);
      tx_burst = (phases == 0);

      for (int k = 0; k < PHASE_CMDS; k++) begin
        // The first phase sends without gaps and asks the sink for its long
        // hold-off, so the block fills up and has to refuse items.
        if (phases == 0 && k == 20) squeeze_req = 1'b1;
        if (phases != 0 && k % 30 == 0) tx_burst = ($urandom_range(0, 4) == 0);

        if ($urandom_range(0, 4) == 0) begin
          // A rear shift followed by ticks, enough to let the correction fire when the delay is short.
          r  = $urandom_range(0, 2);
          fn = (r == 0) ? gssc_pkg::FN_UP : (r == 1) ? gssc_pkg::FN_DOWN : gssc_pkg::FN_TO;
          send_cmd(fn, REAR, 4'($urandom_range(0, 15)), 12'($urandom));
          ticks = (cur.delay > 16) ? 20 : int'(cur.delay) + $urandom_range(1, 3);
          repeat (ticks)
            send_cmd(gssc_pkg::FN_TICK, 1'($urandom_range(0, 1)), 4'($urandom),
                     12'($urandom));
        end else begin
          r  = $urandom_range(0, 99);
          fn = (r < 22) ? gssc_pkg::FN_TICK : (r < 36) ? gssc_pkg::FN_UP :
               (r < 50) ? gssc_pkg::FN_DOWN : (r < 64) ? gssc_pkg::FN_TO :
               (r < 73) ? gssc_pkg::FN_TUNE_UP : (r < 82) ? gssc_pkg::FN_TUNE_DOWN :
               (r < 97) ? gssc_pkg::FN_LOAD : FN_SPARE;
          gi = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 5));
          r  = $urandom_range(0, 9);
          pv = (r == 0) ? 12'd0 : (r == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
          send_cmd(fn, 1'($urandom_range(0, 1)), gi, pv);
        end
      end
      drain;
      phases++;
    end

    $display("Covered %0d items under %0d register settings, %0d register writes in all.",
             cmds_sent, phases + 2, reg_writes);
    $display("Checked %0d servo pulse commands and %0d ignored requests.",
             pulse_cmds, ignored_reqs);
    if (fail_count == 0) begin
      $display("two_servo_gear_shift_controller_test passed");
    end else begin
      $display("two_servo_gear_shift_controller_test failed");
    end
    $finish;
  end

endmodule
